[rtl/rcbp_pkg.sv]
// shared constants, codes and types for the reference-counted block pool
// no dependencies; used by every module of the pool
`default_nettype none
package rcbp_pkg;

	localparam int POOL_BLOCKS = 256;
	localparam int MAX_BATCH  = 16;
	localparam int COUNT_BITS = 8;
	localparam int ID_BITS    = 8;
	localparam int DEPTH_BITS = 9;
	localparam int N_BITS     = 5;
	localparam int OP_BITS    = 3;
	localparam int STAT_BITS  = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [OP_BITS-1:0] OP_ALLOC  = 3'd0;
	localparam logic [OP_BITS-1:0] OP_FREE   = 3'd1;
	localparam logic [OP_BITS-1:0] OP_INCREF = 3'd2;
	localparam logic [OP_BITS-1:0] OP_DECREF = 3'd3;
	localparam logic [OP_BITS-1:0] OP_QUERY  = 3'd4;

	localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_BITS-1:0] ST_NO_BLOCKS = 3'd1;
	localparam logic [STAT_BITS-1:0] ST_BAD_ID    = 3'd2;
	localparam logic [STAT_BITS-1:0] ST_IS_FREE   = 3'd3;
	localparam logic [STAT_BITS-1:0] ST_OVERFLOW  = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_POP_RD = 4'b0010,
		S_POP_WR = 4'b0100,
		S_CNT_EX = 4'b1000
	} state_t;

	// one port of a memory: write when we is set, otherwise read
	typedef struct packed {
		logic               we;
		logic [ID_BITS-1:0] addr;
		logic [ID_BITS-1:0] wdata;
	} stack_req_t;

	typedef struct packed {
		logic                  we;
		logic [ID_BITS-1:0]    addr;
		logic [COUNT_BITS-1:0] wdata;
	} count_req_t;

endpackage
`default_nettype wire

[rtl/rcbp_count_ram.sv]
// reference count memory, one port, registered read data
// depends on rcbp_pkg; entries not yet written read as zero
`default_nettype none
module rcbp_count_ram (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rcbp_pkg::count_req_t          req,
	output logic [rcbp_pkg::COUNT_BITS-1:0]    rdata
);

	logic [rcbp_pkg::COUNT_BITS-1:0] mem [rcbp_pkg::POOL_BLOCKS];
	logic [rcbp_pkg::POOL_BLOCKS-1:0] written_q;
	logic [rcbp_pkg::COUNT_BITS-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (req.we) begin
			written_q[req.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= written_q[req.addr] ? mem[req.addr] : '0;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/rcbp_stack_ram.sv]
// free id stack memory, one port, registered read data
// depends on rcbp_pkg; entry i reads as POOL_BLOCKS-1-i until written
`default_nettype none
module rcbp_stack_ram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rcbp_pkg::stack_req_t       req,
	output logic [rcbp_pkg::ID_BITS-1:0]    rdata
);

	logic [rcbp_pkg::ID_BITS-1:0]    mem [rcbp_pkg::POOL_BLOCKS];
	logic [rcbp_pkg::POOL_BLOCKS-1:0] written_q;
	logic [rcbp_pkg::ID_BITS-1:0]    rdata_q;
	logic [rcbp_pkg::ID_BITS-1:0]    init_val;

	// reset image counts down from the top id
	localparam logic [rcbp_pkg::ID_BITS-1:0] TOP_ID =
		rcbp_pkg::ID_BITS'(rcbp_pkg::POOL_BLOCKS - 1);

	assign init_val = TOP_ID - req.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (req.we) begin
			written_q[req.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= written_q[req.addr] ? mem[req.addr] : init_val;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/refcounted_block_pool.sv]
// channel  | dir | ports                                              | handshake
// command  | in  | opcode, blk_id, alloc_count                        | start & !busy
// result   | out | status, block_valid, returned_id, count_value,     | strobe, one cycle
//          |     | free_blocks, last                                  |
// free, incref, decref and query run as memory read, update, result word.
// alloc of n blocks runs n pops; each pop is a stack read then a count write.
// arst_n resets the fsm, refills the free depth and clears the written flags of both memories.
// the receiver cannot stall; each result word is on the ports for one cycle only.
// depends on rcbp_pkg, rcbp_count_ram and rcbp_stack_ram
`default_nettype none
module refcounted_block_pool (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [rcbp_pkg::OP_BITS-1:0]    opcode,
	input  wire logic [rcbp_pkg::ID_BITS-1:0]    blk_id,
	input  wire logic [rcbp_pkg::N_BITS-1:0]     alloc_count,
	output logic                                 strobe,
	output logic [rcbp_pkg::STAT_BITS-1:0]       status,
	output logic                                 block_valid,
	output logic [rcbp_pkg::ID_BITS-1:0]         returned_id,
	output logic [rcbp_pkg::COUNT_BITS-1:0]      count_value,
	output logic [rcbp_pkg::DEPTH_BITS-1:0]      free_blocks,
	output logic                                 last
);

	localparam logic [rcbp_pkg::DEPTH_BITS-1:0] FULL_DEPTH =
		rcbp_pkg::DEPTH_BITS'(rcbp_pkg::POOL_BLOCKS);
	localparam logic [rcbp_pkg::N_BITS-1:0] BATCH_MAX = rcbp_pkg::N_BITS'(rcbp_pkg::MAX_BATCH);

	rcbp_pkg::state_t state_q, state_d;
	logic [rcbp_pkg::DEPTH_BITS-1:0] depth_q, depth_d;
	logic [rcbp_pkg::N_BITS-1:0]     rem_q, rem_d;
	logic [rcbp_pkg::OP_BITS-1:0]    op_q;
	logic [rcbp_pkg::ID_BITS-1:0]    id_q;

	logic                            strobe_q, strobe_d;
	logic [rcbp_pkg::STAT_BITS-1:0]  status_q, status_d;
	logic                            bvalid_q, bvalid_d;
	logic [rcbp_pkg::ID_BITS-1:0]    rid_q, rid_d;
	logic [rcbp_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [rcbp_pkg::DEPTH_BITS-1:0] free_q, free_d;

	rcbp_pkg::count_req_t            creq;
	rcbp_pkg::stack_req_t            sreq;
	logic [rcbp_pkg::COUNT_BITS-1:0] crdata;
	logic [rcbp_pkg::ID_BITS-1:0]    srdata;

	logic [rcbp_pkg::DEPTH_BITS-1:0] depth_dec;
	logic [rcbp_pkg::DEPTH_BITS-1:0] depth_inc;
	logic [rcbp_pkg::DEPTH_BITS-1:0] depth_end;
	logic                            can_push;
	logic [rcbp_pkg::COUNT_BITS-1:0] cnt_up;
	logic [rcbp_pkg::COUNT_BITS-1:0] cnt_dn;
	logic                            accept;

	rcbp_count_ram u_count_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rdata  (crdata)
	);

	rcbp_stack_ram u_stack_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rdata  (srdata)
	);

	assign busy      = (state_q != rcbp_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign depth_dec = depth_q - 1'b1;
	assign depth_inc = depth_q + 1'b1;
	assign depth_end = depth_q - rcbp_pkg::DEPTH_BITS'(rem_q);
	assign can_push  = (depth_q < FULL_DEPTH);
	assign cnt_up    = crdata + 1'b1;
	assign cnt_dn    = crdata - 1'b1;

	always_comb begin
		state_d  = state_q;
		depth_d  = depth_q;
		rem_d    = rem_q;
		strobe_d = 1'b0;
		status_d = rcbp_pkg::ST_OK;
		bvalid_d = 1'b0;
		rid_d    = '0;
		cnt_d    = '0;
		free_d   = depth_q;
		creq     = '{we: 1'b0, addr: blk_id, wdata: '0};
		sreq     = '{we: 1'b0, addr: depth_dec[rcbp_pkg::ID_BITS-1:0], wdata: '0};

		unique case (state_q)
			rcbp_pkg::S_IDLE: begin
				if (accept) begin
					priority if (opcode == rcbp_pkg::OP_ALLOC) begin
						priority if (alloc_count > BATCH_MAX ||
						             rcbp_pkg::DEPTH_BITS'(alloc_count) > depth_q) begin
							strobe_d = 1'b1;
							status_d = rcbp_pkg::ST_NO_BLOCKS;
						end else if (alloc_count == '0) begin
							strobe_d = 1'b1;
						end else begin
							// stack read at the top goes out now
							rem_d   = alloc_count;
							state_d = rcbp_pkg::S_POP_WR;
						end
					end else if (opcode > rcbp_pkg::OP_QUERY ||
					             32'(blk_id) >= rcbp_pkg::POOL_BLOCKS) begin
						strobe_d = 1'b1;
						status_d = rcbp_pkg::ST_BAD_ID;
					end else begin
						state_d = rcbp_pkg::S_CNT_EX;
					end
				end
			end
			rcbp_pkg::S_POP_RD: begin
				state_d = rcbp_pkg::S_POP_WR;
			end
			rcbp_pkg::S_POP_WR: begin
				creq     = '{we: 1'b1, addr: srdata, wdata: rcbp_pkg::COUNT_BITS'(1)};
				depth_d  = depth_dec;
				rem_d    = rem_q - 1'b1;
				strobe_d = 1'b1;
				bvalid_d = 1'b1;
				rid_d    = srdata;
				cnt_d    = rcbp_pkg::COUNT_BITS'(1);
				free_d   = depth_end;
				state_d  = (rem_q == rcbp_pkg::N_BITS'(1)) ? rcbp_pkg::S_IDLE
				                                           : rcbp_pkg::S_POP_RD;
			end
			rcbp_pkg::S_CNT_EX: begin
				strobe_d = 1'b1;
				state_d  = rcbp_pkg::S_IDLE;
				creq.addr = id_q;
				sreq.addr = depth_q[rcbp_pkg::ID_BITS-1:0];
				sreq.wdata = id_q;
				unique case (op_q)
					rcbp_pkg::OP_FREE: begin
						if (crdata != '0) begin
							creq.we = 1'b1;
							if (can_push) begin
								sreq.we = 1'b1;
								depth_d = depth_inc;
								free_d  = depth_inc;
							end
						end
					end
					rcbp_pkg::OP_INCREF: begin
						priority if (crdata == '0) begin
							status_d = rcbp_pkg::ST_IS_FREE;
						end else if (crdata == rcbp_pkg::COUNT_MAX) begin
							status_d = rcbp_pkg::ST_OVERFLOW;
							cnt_d    = crdata;
						end else begin
							creq.we    = 1'b1;
							creq.wdata = cnt_up;
							cnt_d      = cnt_up;
						end
					end
					rcbp_pkg::OP_DECREF: begin
						if (crdata == '0) begin
							status_d = rcbp_pkg::ST_IS_FREE;
						end else begin
							creq.we    = 1'b1;
							creq.wdata = cnt_dn;
							cnt_d      = cnt_dn;
							// last reference gone: block returns to the stack
							if (cnt_dn == '0 && can_push) begin
								sreq.we = 1'b1;
								depth_d = depth_inc;
								free_d  = depth_inc;
							end
						end
					end
					default: begin
						cnt_d = crdata;
					end
				endcase
			end
			default: begin
				state_d = rcbp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rcbp_pkg::S_IDLE;
			depth_q  <= FULL_DEPTH;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			depth_q  <= depth_d;
			rem_q    <= rem_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			id_q <= blk_id;
		end
		status_q <= status_d;
		bvalid_q <= bvalid_d;
		rid_q    <= rid_d;
		cnt_q    <= cnt_d;
		free_q   <= free_d;
	end

	// every word but an alloc word before the final pop closes the command
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign block_valid = bvalid_q;
	assign returned_id = rid_q;
	assign count_value = cnt_q;
	assign free_blocks = free_q;
	assign last        = strobe_q && (state_q == rcbp_pkg::S_IDLE);

endmodule
`default_nettype wire

[dv/tb_refcounted_block_pool.sv]
// self-checking testbench for refcounted_block_pool: directed and random commands,
// every result word checked against an in-bench model of the counts and the free stack
// depends on rcbp_pkg and the refcounted_block_pool rtl
`default_nettype none
module tb_refcounted_block_pool;

	localparam logic [rcbp_pkg::OP_BITS-1:0] OP_FIRST_BAD = rcbp_pkg::OP_QUERY + 3'd1;
	localparam logic [rcbp_pkg::OP_BITS-1:0] OP_ALL_ONES  = '1;
	localparam logic [rcbp_pkg::N_BITS-1:0]  N_BATCH =
		rcbp_pkg::N_BITS'(rcbp_pkg::MAX_BATCH);
	localparam int RAND_ITEMS  = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic [rcbp_pkg::STAT_BITS-1:0]  status;
		logic                            valid;
		logic [rcbp_pkg::ID_BITS-1:0]    rid;
		logic [rcbp_pkg::COUNT_BITS-1:0] cnt;
		logic [rcbp_pkg::DEPTH_BITS-1:0] nfree;
		logic                            last;
	} pool_word_t;

	typedef struct {
		logic [rcbp_pkg::OP_BITS-1:0] op;
		logic [rcbp_pkg::ID_BITS-1:0] id;
		logic [rcbp_pkg::N_BITS-1:0]  n;
		int                           idle_pct;
	} pool_cmd_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic [rcbp_pkg::OP_BITS-1:0]    opcode = '0;
	logic [rcbp_pkg::ID_BITS-1:0]    blk_id = '0;
	logic [rcbp_pkg::N_BITS-1:0]     alloc_count = '0;
	logic                            busy;
	logic                            strobe;
	logic [rcbp_pkg::STAT_BITS-1:0]  status;
	logic                            block_valid;
	logic [rcbp_pkg::ID_BITS-1:0]    returned_id;
	logic [rcbp_pkg::COUNT_BITS-1:0] count_value;
	logic [rcbp_pkg::DEPTH_BITS-1:0] free_blocks;
	logic                            last;

	// model of the pool
	logic [rcbp_pkg::COUNT_BITS-1:0] pool_cnt [rcbp_pkg::POOL_BLOCKS];
	logic [rcbp_pkg::ID_BITS-1:0]    pool_stack [rcbp_pkg::POOL_BLOCKS];
	int                              pool_depth;

	pool_word_t words_due [$];
	pool_cmd_t  cmds_waiting [$];
	pool_cmd_t  next_cmd;
	pool_word_t got_word;
	int         sender_idle_pct = 0;
	int         err_count = 0;
	int         stall_cycles = 0;

	refcounted_block_pool u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.blk_id      (blk_id),
		.alloc_count (alloc_count),
		.strobe      (strobe),
		.status      (status),
		.block_valid (block_valid),
		.returned_id (returned_id),
		.count_value (count_value),
		.free_blocks (free_blocks),
		.last        (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic push_free_id(input logic [rcbp_pkg::ID_BITS-1:0] id);
		if (pool_depth < rcbp_pkg::POOL_BLOCKS) begin
			pool_stack[pool_depth] = id;
			pool_depth++;
		end
	endtask

	// updates the pool model and queues the result words of one command
	task automatic apply_pool_op(input logic [rcbp_pkg::OP_BITS-1:0] op,
			input logic [rcbp_pkg::ID_BITS-1:0] id, input logic [rcbp_pkg::N_BITS-1:0] n);
		pool_word_t                   w;
		logic [rcbp_pkg::ID_BITS-1:0] taken [$];
		logic [rcbp_pkg::ID_BITS-1:0] b;
		w = '0;
		w.last = 1'b1;
		if (op == rcbp_pkg::OP_ALLOC) begin
			// all or nothing, batches above the limit are refused like an empty pool
			if (int'(n) > rcbp_pkg::MAX_BATCH || int'(n) > pool_depth) begin
				w.status = rcbp_pkg::ST_NO_BLOCKS;
			end else begin
				for (int i = 0; i < int'(n); i++) begin
					pool_depth--;
					b = pool_stack[pool_depth];
					pool_cnt[b] = rcbp_pkg::COUNT_BITS'(1);
					taken.insert(taken.size(), b);
				end
			end
			if (taken.size() == 0) begin
				w.nfree = rcbp_pkg::DEPTH_BITS'(pool_depth);
				words_due.insert(words_due.size(), w);
			end
			foreach (taken[i]) begin
				w.valid = 1'b1;
				w.rid = taken[i];
				w.cnt = rcbp_pkg::COUNT_BITS'(1);
				w.nfree = rcbp_pkg::DEPTH_BITS'(pool_depth);
				w.last = (i == taken.size() - 1);
				words_due.insert(words_due.size(), w);
			end
		end else if (op > rcbp_pkg::OP_QUERY || int'(id) >= rcbp_pkg::POOL_BLOCKS) begin
			w.status = rcbp_pkg::ST_BAD_ID;
			w.nfree = rcbp_pkg::DEPTH_BITS'(pool_depth);
			words_due.insert(words_due.size(), w);
		end else begin
			case (op)
				rcbp_pkg::OP_FREE: begin
					// freeing a free block is a silent no-op
					if (pool_cnt[id] != 0) begin
						pool_cnt[id] = 0;
						push_free_id(id);
					end
				end
				rcbp_pkg::OP_INCREF: begin
					if (pool_cnt[id] == 0) begin
						w.status = rcbp_pkg::ST_IS_FREE;
					end else if (pool_cnt[id] == rcbp_pkg::COUNT_MAX) begin
						w.status = rcbp_pkg::ST_OVERFLOW;
						w.cnt = rcbp_pkg::COUNT_MAX;
					end else begin
						pool_cnt[id] = pool_cnt[id] + 1'b1;
						w.cnt = pool_cnt[id];
					end
				end
				rcbp_pkg::OP_DECREF: begin
					if (pool_cnt[id] == 0) begin
						w.status = rcbp_pkg::ST_IS_FREE;
					end else begin
						pool_cnt[id] = pool_cnt[id] - 1'b1;
						if (pool_cnt[id] == 0)
							push_free_id(id);
						w.cnt = pool_cnt[id];
					end
				end
				default: begin
					w.cnt = pool_cnt[id];
				end
			endcase
			w.nfree = rcbp_pkg::DEPTH_BITS'(pool_depth);
			words_due.insert(words_due.size(), w);
		end
	endtask

	task automatic cmp_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			if (err_count < 200)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
					act_val);
			err_count++;
		end
	endtask

	task automatic queue_cmd(input logic [rcbp_pkg::OP_BITS-1:0] op,
			input logic [rcbp_pkg::ID_BITS-1:0] id, input logic [rcbp_pkg::N_BITS-1:0] n);
		pool_cmd_t c;
		// stay at most two commands ahead so picks of live blocks are mostly current
		while (cmds_waiting.size() >= 2)
			@(negedge clk);
		c.op = op;
		c.id = id;
		c.n = n;
		c.idle_pct = sender_idle_pct;
		cmds_waiting.insert(cmds_waiting.size(), c);
	endtask

	function automatic logic [rcbp_pkg::ID_BITS-1:0] rand_id();
		return rcbp_pkg::ID_BITS'($urandom_range(255));
	endfunction

	function automatic logic [rcbp_pkg::N_BITS-1:0] rand_n();
		return rcbp_pkg::N_BITS'($urandom_range(31));
	endfunction

	function automatic logic [rcbp_pkg::ID_BITS-1:0] pick_live();
		logic [rcbp_pkg::ID_BITS-1:0] ids [$];
		for (int b = 0; b < rcbp_pkg::POOL_BLOCKS; b++)
			if (pool_cnt[b] != 0)
				ids.insert(ids.size(), rcbp_pkg::ID_BITS'(b));
		if (ids.size() == 0)
			return rcbp_pkg::ID_BITS'($urandom_range(rcbp_pkg::POOL_BLOCKS - 1));
		return ids[$urandom_range(ids.size() - 1)];
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				apply_pool_op(opcode, blk_id, alloc_count);
			if (!start || !busy) begin
				if (cmds_waiting.size() != 0 &&
						$urandom_range(99) >= cmds_waiting[0].idle_pct) begin
					next_cmd = cmds_waiting.pop_front();
					start <= 1'b1;
					opcode <= next_cmd.op;
					blk_id <= next_cmd.id;
					alloc_count <= next_cmd.n;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe !== 1'b0) begin
			if (words_due.size() == 0) begin
				$display("%0t: result word with none expected, %s %0d id %0d", $time,
					"expected none, actual status", status, returned_id);
				err_count++;
			end else begin
				got_word = words_due.pop_front();
				cmp_field("strobe", 16'(1'b1), 16'(strobe));
				cmp_field("status", 16'(got_word.status), 16'(status));
				cmp_field("block_valid", 16'(got_word.valid), 16'(block_valid));
				cmp_field("returned_id", 16'(got_word.rid), 16'(returned_id));
				cmp_field("count_value", 16'(got_word.cnt), 16'(count_value));
				cmp_field("free_blocks", 16'(got_word.nfree), 16'(free_blocks));
				cmp_field("last", 16'(got_word.last), 16'(last));
			end
		end
	end

	// watchdog on cycles with no command and no result word
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe === 1'b1) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int                           sel;
		int                           nsel;
		logic [rcbp_pkg::ID_BITS-1:0] hot;
		for (int b = 0; b < rcbp_pkg::POOL_BLOCKS; b++) begin
			pool_cnt[b] = '0;
			pool_stack[b] = rcbp_pkg::ID_BITS'(rcbp_pkg::POOL_BLOCKS - 1 - b);
		end
		pool_depth = rcbp_pkg::POOL_BLOCKS;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed: commands on free blocks, batch limits, bad codes
		queue_cmd(rcbp_pkg::OP_QUERY, 8'd0, 5'd0);
		queue_cmd(rcbp_pkg::OP_INCREF, 8'd5, 5'd0);
		queue_cmd(rcbp_pkg::OP_DECREF, 8'd255, 5'd31);
		queue_cmd(rcbp_pkg::OP_FREE, 8'd7, 5'd0);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, 5'd0);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, N_BATCH + 5'd1);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd255, 5'd31);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, N_BATCH);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, 5'd1);
		queue_cmd(OP_FIRST_BAD, 8'd0, 5'd0);
		queue_cmd(OP_ALL_ONES, 8'd255, 5'd31);
		queue_cmd(rcbp_pkg::OP_INCREF, 8'd3, 5'd0);
		queue_cmd(rcbp_pkg::OP_INCREF, 8'd3, 5'd0);
		queue_cmd(rcbp_pkg::OP_DECREF, 8'd3, 5'd0);
		queue_cmd(rcbp_pkg::OP_QUERY, 8'd3, 5'd0);
		queue_cmd(rcbp_pkg::OP_DECREF, 8'd16, 5'd0);
		queue_cmd(rcbp_pkg::OP_QUERY, 8'd16, 5'd0);
		queue_cmd(rcbp_pkg::OP_FREE, 8'd0, 5'd0);
		queue_cmd(rcbp_pkg::OP_FREE, 8'd0, 5'd0);
		queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, 5'd2);
		queue_cmd(rcbp_pkg::OP_QUERY, 8'd255, 5'd0);
		queue_cmd(rcbp_pkg::OP_DECREF, 8'd15, 5'd0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			case ((i / 10) % 4)
				1: sender_idle_pct = 70;
				3: sender_idle_pct = 24;
				default: sender_idle_pct = 0;
			endcase
			if (i == 12) begin
				// run the pool dry, then hand some blocks back
				for (int k = 0; k < rcbp_pkg::POOL_BLOCKS / rcbp_pkg::MAX_BATCH + 1; k++)
					queue_cmd(rcbp_pkg::OP_ALLOC, rand_id(), N_BATCH);
				for (int k = 0; k < rcbp_pkg::MAX_BATCH + 1; k++)
					queue_cmd(rcbp_pkg::OP_ALLOC, rand_id(), 5'd1);
				for (int k = 0; k < 16; k++)
					queue_cmd(rcbp_pkg::OP_FREE, pick_live(), rand_n());
			end
			if (i == 25) begin
				// saturate one count, settle first so the chosen block is really live
				while (cmds_waiting.size() != 0 || start)
					@(negedge clk);
				if (pool_depth == rcbp_pkg::POOL_BLOCKS) begin
					queue_cmd(rcbp_pkg::OP_ALLOC, 8'd0, 5'd1);
					while (cmds_waiting.size() != 0 || start)
						@(negedge clk);
				end
				hot = pick_live();
				for (int k = 0; k < (1 << rcbp_pkg::COUNT_BITS); k++)
					queue_cmd(rcbp_pkg::OP_INCREF, hot, rand_n());
				queue_cmd(rcbp_pkg::OP_QUERY, hot, 5'd0);
				queue_cmd(rcbp_pkg::OP_DECREF, hot, 5'd0);
				queue_cmd(rcbp_pkg::OP_INCREF, hot, 5'd0);
			end
			sel = $urandom_range(99);
			if (sel < 30) begin
				nsel = $urandom_range(99);
				if (nsel < 60)
					nsel = $urandom_range(4);
				else if (nsel < 90)
					nsel = $urandom_range(rcbp_pkg::MAX_BATCH, 5);
				else
					nsel = $urandom_range(31, rcbp_pkg::MAX_BATCH + 1);
				queue_cmd(rcbp_pkg::OP_ALLOC, rand_id(), rcbp_pkg::N_BITS'(nsel));
			end else if (sel < 75) begin
				nsel = $urandom_range(99);
				hot = pick_live();
				if (nsel < 35)
					queue_cmd(rcbp_pkg::OP_INCREF, hot, rand_n());
				else if (nsel < 65)
					queue_cmd(rcbp_pkg::OP_DECREF, hot, rand_n());
				else if (nsel < 80)
					queue_cmd(rcbp_pkg::OP_QUERY, hot, rand_n());
				else
					queue_cmd(rcbp_pkg::OP_FREE, hot, rand_n());
			end else if (sel < 94) begin
				queue_cmd(rcbp_pkg::OP_BITS'($urandom_range(rcbp_pkg::OP_QUERY,
					rcbp_pkg::OP_FREE)), rand_id(), rand_n());
			end else begin
				queue_cmd(rcbp_pkg::OP_BITS'($urandom_range(OP_ALL_ONES, OP_FIRST_BAD)),
					rand_id(), rand_n());
			end
		end

		while (cmds_waiting.size() != 0 || start || words_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT)
			@(negedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/rcbp_pkg.sv
rtl/rcbp_count_ram.sv
rtl/rcbp_stack_ram.sv
rtl/refcounted_block_pool.sv
dv/tb_refcounted_block_pool.sv
